// File: design/sorted_multimap_table_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted multimap table.
// Each macro samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_MULTIMAP_TABLE_DEFINES_SVH
`define SORTED_MULTIMAP_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define SMM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_multimap_table: same-cycle check failed");
// Next-cycle implication.
`define SMM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_multimap_table: next-cycle check failed");
`else
`define SMM_ASSERT_IMP(lbl, ante, cons)
`define SMM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: design/smm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_pkg
// Types and codes shared by the sorted multimap table modules.
// ----------------------------------------------------------------------------
package smm_pkg;

  typedef logic [1:0]         func_t;
  typedef logic [1:0]         status_t;
  typedef logic signed [31:0] word_t;

  // Operation codes.
  localparam func_t FUNC_ADD    = 2'd0;
  localparam func_t FUNC_SEARCH = 2'd1;
  localparam func_t FUNC_REMOVE = 2'd2;

  // Result status codes.
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_FULL = 2'd2;

  // Width of the pair count field in a result word.
  localparam int PAIR_COUNT_W = 7;

  // One stored key and value pair.
  typedef struct packed {
    word_t key;
    word_t value;
  } pair_t;

endpackage

// File: design/smm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_in_if / smm_out_if
// Valid/ready channels carrying command words in and result words out.
// ----------------------------------------------------------------------------
interface smm_in_if;
  logic                valid;
  logic                ready;
  smm_pkg::func_t      func;
  smm_pkg::word_t      key_in;
  smm_pkg::word_t      value_in;

  modport source (output valid, func, key_in, value_in, input ready);
  modport sink   (input valid, func, key_in, value_in, output ready);
endinterface

interface smm_out_if;
  logic                              valid;
  logic                              ready;
  smm_pkg::status_t                  status;
  smm_pkg::word_t                    value_out;
  logic                              last;
  logic [smm_pkg::PAIR_COUNT_W-1:0]  pair_count;

  modport source (output valid, status, value_out, last, pair_count, input ready);
  modport sink   (input valid, status, value_out, last, pair_count, output ready);
endinterface

// File: design/smm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_cell
// One storage cell of the table ring: holds a pair and loads its neighbor's.
// ----------------------------------------------------------------------------
module smm_cell (
  input  logic           clk,
  input  logic           shift_en,
  input  smm_pkg::pair_t pair_in,
  output smm_pkg::pair_t pair_out
);

  smm_pkg::pair_t pair_r;

  // The pair moves one place toward the head whenever the ring steps.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      pair_r <= pair_in;
    end
  end

  assign pair_out = pair_r;

endmodule

// File: design/sorted_multimap_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_multimap_table
// Bounded sorted multimap held in a ring of cells that a head unit walks.
//
//   Channel  Dir  Handshake            Word
//   in_ch    in   valid/ready          func, key_in, value_in
//   out_ch   out  valid/ready          status, value_out, last, pair_count
//   cfg      in   cfg_we, no wait      cfg_wdata (descending order)
//
// Add, search and remove each rotate the ring once in ENTRIES steps. Add,
// remove and a search miss go from the idle state through the walk to a
// posting state for the result. A search hit posts its words during the
// walk and goes back to idle. A full add or an unused code goes from idle
// straight to the posting state. A stalled result word holds the ring, or
// the posting state, until it is taken. Reset empties the table at once.
// ----------------------------------------------------------------------------
`include "sorted_multimap_table_defines.svh"

module sorted_multimap_table #(
  parameter int ENTRIES = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cfg_we,
  input  logic  cfg_wdata,
  smm_in_if.sink    in_ch,
  smm_out_if.source out_ch
);

  localparam int SW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [SW-1:0] LAST_STEP = SW'(ENTRIES - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  // Control and operand registers.
  logic [1:0]         state_r, state_nxt;
  logic [SW-1:0]      step_r, step_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic               desc_r;
  smm_pkg::func_t     op_r, op_nxt;
  smm_pkg::word_t     key_r, key_nxt;
  smm_pkg::word_t     val_r, val_nxt;
  smm_pkg::pair_t     carry_r, carry_nxt;
  logic               match_r, match_nxt;
  logic               hit_r, hit_nxt;
  smm_pkg::status_t   fin_status_r, fin_status_nxt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  smm_pkg::status_t   out_status_r, out_status_nxt;
  smm_pkg::word_t     out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;
  logic [smm_pkg::PAIR_COUNT_W-1:0] out_count_r, out_count_nxt;

  // Ring signals.
  smm_pkg::pair_t     cell_q [ENTRIES];
  smm_pkg::pair_t     tail;
  smm_pkg::pair_t     c0, c1;
  logic               step_en;
  logic               emit, emit_last;
  logic               v0, v1, goes_before, slot_free, in_fire, full_add;
  logic [CW+smm_pkg::PAIR_COUNT_W-1:0] cnt_ext;

  assign c0 = cell_q[0];
  assign c1 = cell_q[1];

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign full_add  = in_fire && (in_ch.func == smm_pkg::FUNC_ADD) && (n_r == FULL_CNT);

  // Validity of the head entries follows from the step and the pair count.
  assign v0 = CW'(step_r) < n_r;
  assign v1 = ((CW + 1)'(step_r) + (CW + 1)'(1)) < (CW + 1)'(n_r);

  assign goes_before = desc_r ? ($signed(c0.key) <= $signed(key_r))
                              : ($signed(key_r) <= $signed(c0.key));

  assign cnt_ext = (CW + smm_pkg::PAIR_COUNT_W)'(n_r);

  // Ring of cells: each takes its neighbor's pair, the last takes the head unit's tail pair.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    smm_pkg::pair_t cell_in;
    if (i == ENTRIES - 1) begin : g_tail
      assign cell_in = tail;
    end else begin : g_mid
      assign cell_in = cell_q[i+1];
    end
    smm_cell u_cell (
      .clk      (clk),
      .shift_en (step_en),
      .pair_in  (cell_in),
      .pair_out (cell_q[i])
    );
  end

  // Head unit: steps the ring and decides what reenters at the tail.
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    n_nxt          = n_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    carry_nxt      = carry_r;
    match_nxt      = match_r;
    hit_nxt        = hit_r;
    fin_status_nxt = fin_status_r;
    tail           = c0;
    emit           = 1'b0;
    emit_last      = 1'b0;
    step_en        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_ch.func;
          key_nxt   = in_ch.key_in;
          val_nxt   = in_ch.value_in;
          step_nxt  = '0;
          match_nxt = 1'b0;
          hit_nxt   = 1'b0;
          case (in_ch.func) inside
            smm_pkg::FUNC_ADD: begin
              if (full_add) begin
                fin_status_nxt = smm_pkg::ST_FULL;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_WALK;
              end
            end
            smm_pkg::FUNC_SEARCH, smm_pkg::FUNC_REMOVE: begin
              state_nxt = S_WALK;
            end
            default: begin
              fin_status_nxt = smm_pkg::ST_MISS;
              state_nxt      = S_FIN;
            end
          endcase
        end
      end

      S_WALK: begin
        case (op_r)
          smm_pkg::FUNC_ADD: begin
            // Once the new pair is in, every entry comes back one step late.
            if (match_r) begin
              tail      = carry_r;
              carry_nxt = c0;
            end else if (!v0 || goes_before) begin
              tail      = '{key: key_r, value: val_r};
              carry_nxt = c0;
              match_nxt = 1'b1;
            end
          end
          smm_pkg::FUNC_SEARCH: begin
            // Only the first run of matching keys is reported.
            emit      = !match_r && v0 && (c0.key == key_r);
            emit_last = !v1 || (c1.key != key_r);
            if (emit) begin
              hit_nxt = 1'b1;
              if (emit_last) begin
                match_nxt = 1'b1;
              end
            end
          end
          default: begin
            // Remove: after the deleted entry the ring takes the next one.
            if (match_r) begin
              tail = c1;
            end else if (v0 && (c0.key == key_r) && (c0.value == val_r)) begin
              tail      = c1;
              match_nxt = 1'b1;
            end
          end
        endcase

        step_en = !emit || slot_free;
        if (!step_en) begin
          carry_nxt = carry_r;
          match_nxt = match_r;
          hit_nxt   = hit_r;
        end else begin
          step_nxt = step_r + SW'(1);
          if (step_r == LAST_STEP) begin
            step_nxt = '0;
            case (op_r)
              smm_pkg::FUNC_ADD: begin
                n_nxt          = n_r + CW'(1);
                fin_status_nxt = smm_pkg::ST_OK;
                state_nxt      = S_FIN;
              end
              smm_pkg::FUNC_SEARCH: begin
                fin_status_nxt = smm_pkg::ST_MISS;
                state_nxt      = hit_nxt ? S_IDLE : S_FIN;
              end
              default: begin
                if (match_nxt) begin
                  n_nxt          = n_r - CW'(1);
                  fin_status_nxt = smm_pkg::ST_OK;
                end else begin
                  fin_status_nxt = smm_pkg::ST_MISS;
                end
                state_nxt = S_FIN;
              end
            endcase
          end
        end
      end

      S_FIN: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register: search hits load during the walk, others at the end.
  always_comb begin
    out_valid_nxt  = out_ch.ready ? 1'b0 : out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_count_nxt  = out_count_r;
    if (state_r == S_WALK && emit && step_en) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = smm_pkg::ST_OK;
      out_value_nxt  = c0.value;
      out_last_nxt   = emit_last;
      out_count_nxt  = cnt_ext[smm_pkg::PAIR_COUNT_W-1:0];
    end else if (state_r == S_FIN && slot_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = fin_status_r;
      out_value_nxt  = '0;
      out_last_nxt   = 1'b1;
      out_count_nxt  = cnt_ext[smm_pkg::PAIR_COUNT_W-1:0];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      n_r         <= '0;
      desc_r      <= 1'b0;
      match_r     <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      n_r         <= n_nxt;
      match_r     <= match_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        desc_r <= cfg_wdata;
      end
    end
  end

  // Operands and result payload.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    carry_r      <= carry_nxt;
    fin_status_r <= fin_status_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.value_out  = out_value_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.pair_count = out_count_r;

  // The pair count never passes the table size.
  `SMM_ASSERT_IMP(a_count_bound, 1'b1, n_r <= FULL_CNT)
  // An add to a full table leaves the count alone and goes straight to the result.
  `SMM_ASSERT_NXT(a_full_add, full_add, n_r == $past(n_r) && state_r == S_FIN)
  // The walk ends after the last step of the ring.
  `SMM_ASSERT_NXT(a_walk_ends, step_en && step_r == LAST_STEP, state_r != S_WALK)
  // The count only changes at the end of a walk.
  `SMM_ASSERT_NXT(a_count_steady, state_r != S_WALK, n_r == $past(n_r))

endmodule
